### rtl/core/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared widths, reset values, microcode word layout and codes for the
// temperature duty controller core.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int TEMP_W     = 16;
    localparam int TGT_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int ERR_W      = 18;
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 20;
    localparam int PROD_W     = MUL_A_W + 1 + MUL_B_W;
    localparam int ACC_W      = 36;
    localparam int CHUNK_W    = 17;
    localparam int CEIL_W     = 2 * CHUNK_W;
    localparam int DUTY_W     = 16;
    localparam int NUM_W      = CEIL_W + DUTY_W;
    localparam int DRIVE_W    = 18;
    localparam int DRIVE_SH   = 16;
    localparam int STEP_W     = 4;
    localparam int DCNT_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CEIL_W:0] ROUND_HALF = (CEIL_W+1)'(1) << (DRIVE_SH - 1);

    localparam logic [TGT_W-1:0]  TARGET_RST     = 8'd30;
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd6554;
    localparam logic [GAIN_W-1:0] GAIN_SUM_RST   = 16'd655;
    localparam logic [GAIN_W-1:0] GAIN_DIFF_RST  = 16'd0;
    localparam logic [GAIN_W-1:0] DUTY_SCALE_RST = 16'd47841;
    localparam logic signed [ERR_W-1:0] PREV_ERR_RST = 18'sd7680;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_TEMP = 3'd0,
        CFG_GAIN_PROP   = 3'd1,
        CFG_GAIN_SUM    = 3'd2,
        CFG_GAIN_DIFF   = 3'd3,
        CFG_DUTY_SCALE  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [TGT_W-1:0]  target_temp;
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_sum;
        logic [GAIN_W-1:0] gain_diff;
        logic [GAIN_W-1:0] duty_scale;
    } cfg_t;

    typedef enum logic [2:0] {
        A_GP, A_GD, A_GS, A_CEIL, A_DS
    } a_sel_t;

    typedef enum logic [2:0] {
        B_ERR, B_DIFF, B_SUM, B_TGT, B_CLO, B_CHI
    } b_sel_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_CAPTURE, OP_MUL_LOAD, OP_MUL_ADD, OP_CEIL, OP_CLAMP,
        OP_NUM_LO, OP_NUM_HI, OP_DIV_INIT, OP_DIV_STEP
    } dp_op_t;

    typedef enum logic [2:0] {
        SEQ_NEXT, SEQ_WAIT_IN, SEQ_JUMP_ZERO, SEQ_LOOP_DIV, SEQ_EMIT
    } seq_op_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_MUL_P    = 4'd1;
    localparam step_t STEP_MUL_D    = 4'd2;
    localparam step_t STEP_MUL_S    = 4'd3;
    localparam step_t STEP_CEIL     = 4'd4;
    localparam step_t STEP_CLAMP    = 4'd5;
    localparam step_t STEP_NUM_LO   = 4'd6;
    localparam step_t STEP_NUM_HI   = 4'd7;
    localparam step_t STEP_DIV_INIT = 4'd8;
    localparam step_t STEP_DIV_STEP = 4'd9;
    localparam step_t STEP_EMIT     = 4'd10;

    typedef struct packed {
        dp_op_t  op;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        seq_op_t seq;
        step_t   target;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   capture;
        logic   out_load;
    } dp_ctrl_t;

    typedef struct packed {
        logic ceil_zero;
        logic div_last;
    } dp_status_t;

endpackage

### rtl/core/tpd_ucode_rom.sv
// ----------------------------------------------------------------------------
// tpd_ucode_rom
// Control store: one microcode word per program step.
// ----------------------------------------------------------------------------
module tpd_ucode_rom (
    input  tpd_pkg::step_t  step,
    output tpd_pkg::ucode_t uc
);
    import tpd_pkg::*;

    always_comb begin
        case (step)
            STEP_IDLE:     uc = '{op: OP_CAPTURE,  a_sel: A_GP,   b_sel: B_ERR,
                                  seq: SEQ_WAIT_IN, target: STEP_IDLE};
            STEP_MUL_P:    uc = '{op: OP_MUL_LOAD, a_sel: A_GP,   b_sel: B_ERR,
                                  seq: SEQ_NEXT, target: STEP_IDLE};
            STEP_MUL_D:    uc = '{op: OP_MUL_ADD,  a_sel: A_GD,   b_sel: B_DIFF,
                                  seq: SEQ_NEXT, target: STEP_IDLE};
            STEP_MUL_S:    uc = '{op: OP_MUL_ADD,  a_sel: A_GS,   b_sel: B_SUM,
                                  seq: SEQ_NEXT, target: STEP_IDLE};
            STEP_CEIL:     uc = '{op: OP_CEIL,     a_sel: A_CEIL, b_sel: B_TGT,
                                  seq: SEQ_NEXT, target: STEP_IDLE};
            STEP_CLAMP:    uc = '{op: OP_CLAMP,    a_sel: A_GP,   b_sel: B_ERR,
                                  seq: SEQ_NEXT, target: STEP_IDLE};
            STEP_NUM_LO:   uc = '{op: OP_NUM_LO,   a_sel: A_DS,   b_sel: B_CLO,
                                  seq: SEQ_NEXT, target: STEP_IDLE};
            STEP_NUM_HI:   uc = '{op: OP_NUM_HI,   a_sel: A_DS,   b_sel: B_CHI,
                                  seq: SEQ_NEXT, target: STEP_IDLE};
            STEP_DIV_INIT: uc = '{op: OP_DIV_INIT, a_sel: A_GP,   b_sel: B_ERR,
                                  seq: SEQ_JUMP_ZERO, target: STEP_EMIT};
            STEP_DIV_STEP: uc = '{op: OP_DIV_STEP, a_sel: A_GP,   b_sel: B_ERR,
                                  seq: SEQ_LOOP_DIV, target: STEP_DIV_STEP};
            STEP_EMIT:     uc = '{op: OP_NOP,      a_sel: A_GP,   b_sel: B_ERR,
                                  seq: SEQ_EMIT, target: STEP_IDLE};
            default:       uc = '{op: OP_NOP,      a_sel: A_GP,   b_sel: B_ERR,
                                  seq: SEQ_EMIT, target: STEP_IDLE};
        endcase
    end

endmodule

### rtl/core/tpd_datapath.sv
// ----------------------------------------------------------------------------
// tpd_datapath
// Error capture, shared multiplier with accumulator, clamp, restoring
// divider and output registers, all driven by the microcode word.
// ----------------------------------------------------------------------------
module tpd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tpd_pkg::cfg_t                       cfg,
    input  tpd_pkg::dp_ctrl_t                   ctrl,
    input  logic signed [tpd_pkg::TEMP_W-1:0]   s_measured_temp,
    output tpd_pkg::dp_status_t                 status,
    output logic [tpd_pkg::DUTY_W-1:0]          m_pwm_duty,
    output logic [tpd_pkg::DRIVE_W-1:0]         m_drive_level,
    output logic                                m_ceiling_zero
);
    import tpd_pkg::*;

    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [CEIL_W-1:0]         ceil_reg, ceil_next;
    logic [CEIL_W-1:0]         clamp_reg, clamp_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [CEIL_W-1:0]         rem_reg, rem_next;
    logic [DUTY_W-1:0]         quot_reg, quot_next;
    logic [DCNT_W-1:0]         dcnt_reg, dcnt_next;
    logic [DUTY_W-1:0]         duty_reg;
    logic [DRIVE_W-1:0]        drive_reg;
    logic                      zero_reg;

    logic [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [CEIL_W:0]           div_trial;
    logic [CEIL_W:0]           div_d;
    logic                      div_ge;
    logic [CEIL_W:0]           drive_round;

    always_comb begin
        case (ctrl.uc.a_sel)
            A_GP:    mul_a = {2'b00, cfg.gain_prop};
            A_GD:    mul_a = {2'b00, cfg.gain_diff};
            A_GS:    mul_a = {2'b00, cfg.gain_sum};
            A_CEIL:  mul_a = {2'b00, cfg.gain_prop} + {1'b0, cfg.gain_sum, 1'b0};
            A_DS:    mul_a = {2'b00, cfg.duty_scale};
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (ctrl.uc.b_sel)
            B_ERR:   mul_b = MUL_B_W'(err_reg);
            B_DIFF:  mul_b = MUL_B_W'(err_reg) - MUL_B_W'(prev_err_reg);
            B_SUM:   mul_b = MUL_B_W'(err_reg) + MUL_B_W'(prev_err_reg);
            B_TGT:   mul_b = {{(MUL_B_W-TGT_W){1'b0}}, cfg.target_temp};
            B_CLO:   mul_b = {{(MUL_B_W-CHUNK_W){1'b0}}, clamp_reg[CHUNK_W-1:0]};
            B_CHI:   mul_b = {{(MUL_B_W-CHUNK_W){1'b0}}, clamp_reg[CEIL_W-1:CHUNK_W]};
            default: mul_b = '0;
        endcase
    end

    assign prod      = signed'({1'b0, mul_a}) * mul_b;
    assign div_trial = {rem_reg, num_reg[DUTY_W-1]};
    assign div_d     = div_trial - {1'b0, ceil_reg};
    assign div_ge    = div_trial >= {1'b0, ceil_reg};
    assign drive_round = {1'b0, clamp_reg} + ROUND_HALF;

    always_comb begin
        err_next      = err_reg;
        prev_err_next = prev_err_reg;
        acc_next      = acc_reg;
        ceil_next     = ceil_reg;
        clamp_next    = clamp_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        dcnt_next     = dcnt_reg;
        case (ctrl.uc.op)
            OP_CAPTURE: begin
                if (ctrl.capture) begin
                    err_next = signed'({2'b00, cfg.target_temp, {FRAC_W{1'b0}}})
                             - ERR_W'(s_measured_temp);
                end
            end
            OP_MUL_LOAD: acc_next = signed'(prod[ACC_W-1:0]);
            OP_MUL_ADD:  acc_next = acc_reg + signed'(prod[ACC_W-1:0]);
            OP_CEIL:     ceil_next = {prod[CEIL_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            OP_CLAMP: begin
                prev_err_next = err_reg;
                if (acc_reg[ACC_W-1]) begin
                    clamp_next = '0;
                end else if (acc_reg[ACC_W-2:0] > {1'b0, ceil_reg}) begin
                    clamp_next = ceil_reg;
                end else begin
                    clamp_next = acc_reg[CEIL_W-1:0];
                end
            end
            OP_NUM_LO: num_next = {{(NUM_W-CEIL_W){1'b0}}, prod[CEIL_W-1:0]};
            OP_NUM_HI: num_next = num_reg + {prod[NUM_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            OP_DIV_INIT: begin
                rem_next  = num_reg[NUM_W-1:DUTY_W];
                quot_next = '0;
                dcnt_next = DCNT_W'(DUTY_W);
            end
            OP_DIV_STEP: begin
                rem_next  = div_ge ? div_d[CEIL_W-1:0] : div_trial[CEIL_W-1:0];
                quot_next = {quot_reg[DUTY_W-2:0], div_ge};
                num_next  = num_reg << 1;
                dcnt_next = dcnt_reg - DCNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= PREV_ERR_RST;
        end else begin
            prev_err_reg <= prev_err_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg   <= err_next;
        acc_reg   <= acc_next;
        ceil_reg  <= ceil_next;
        clamp_reg <= clamp_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        dcnt_reg  <= dcnt_next;
        if (ctrl.out_load) begin
            duty_reg  <= status.ceil_zero ? '0 : quot_reg;
            drive_reg <= drive_round[DRIVE_SH+DRIVE_W-1:DRIVE_SH];
            zero_reg  <= status.ceil_zero;
        end
    end

    assign status.ceil_zero = (ceil_reg == '0);
    assign status.div_last  = (dcnt_reg == DCNT_W'(1));

    assign m_pwm_duty     = duty_reg;
    assign m_drive_level  = drive_reg;
    assign m_ceiling_zero = zero_reg;

    a_rem_below_ceil: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.uc.op == OP_DIV_STEP) |-> (rem_reg < ceil_reg))
        else $error("divider remainder not below ceiling");

    a_clamp_le_ceil: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.uc.op == OP_CLAMP) |=> (clamp_reg <= ceil_reg))
        else $error("clamped drive above ceiling");

    a_zero_ceil_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.out_load && status.ceil_zero) |-> (clamp_reg == '0))
        else $error("nonzero drive with zero ceiling");

endmodule

### rtl/core/tpd_sequencer.sv
// ----------------------------------------------------------------------------
// tpd_sequencer
// Step counter over the control store with conditional jumps, input and
// result handshakes.
// ----------------------------------------------------------------------------
module tpd_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  tpd_pkg::dp_status_t status,
    output tpd_pkg::dp_ctrl_t   ctrl
);
    import tpd_pkg::*;

    step_t  step_reg, step_next;
    logic   m_valid_reg, m_valid_next;
    ucode_t uc;
    logic   capture;
    logic   out_free;
    logic   out_load;

    tpd_ucode_rom u_rom (
        .step (step_reg),
        .uc   (uc)
    );

    assign s_ready  = (uc.seq == SEQ_WAIT_IN);
    assign capture  = s_ready && s_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (uc.seq == SEQ_EMIT) && out_free;

    always_comb begin
        case (uc.seq)
            SEQ_NEXT:      step_next = step_reg + STEP_W'(1);
            SEQ_WAIT_IN:   step_next = capture ? step_reg + STEP_W'(1) : step_reg;
            SEQ_JUMP_ZERO: step_next = status.ceil_zero ? uc.target : step_reg + STEP_W'(1);
            SEQ_LOOP_DIV:  step_next = status.div_last ? step_reg + STEP_W'(1) : uc.target;
            SEQ_EMIT:      step_next = out_load ? uc.target : step_reg;
            default:       step_next = STEP_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign ctrl.uc       = uc;
    assign ctrl.capture  = capture;
    assign ctrl.out_load = out_load;

    a_capture_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        capture |=> (step_reg == STEP_MUL_P))
        else $error("program did not start after input transfer");

    a_load_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid_reg && step_reg == STEP_IDLE))
        else $error("result load did not return to idle step");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (uc.seq == SEQ_EMIT && m_valid_reg && !m_ready) |=> (step_reg == STEP_EMIT))
        else $error("pending result overrun");

endmodule

### rtl/core/temperature_pi_duty_controller_core.sv
// ----------------------------------------------------------------------------
// temperature_pi_duty_controller_core
// Program: error capture; proportional, difference and sum products on the single
// shared multiplier; ceiling; clamp; numerator low and high; restoring divide loop,
// skipped with a zero ceiling; result load. A new input waits for that result load.
// Reset: synchronous, active low; configuration registers return to their reset
// values, the program to idle with no result pending, the previous error to 30.0.
// ----------------------------------------------------------------------------
module temperature_pi_duty_controller_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [tpd_pkg::TEMP_W-1:0]    s_measured_temp,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tpd_pkg::DUTY_W-1:0]           m_pwm_duty,
    output logic [tpd_pkg::DRIVE_W-1:0]          m_drive_level,
    output logic                                 m_ceiling_zero
);
    import tpd_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    dp_ctrl_t   ctrl;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_TARGET_TEMP: cfg_next.target_temp = cfg_data[TGT_W-1:0];
                CFG_GAIN_PROP:   cfg_next.gain_prop   = cfg_data[GAIN_W-1:0];
                CFG_GAIN_SUM:    cfg_next.gain_sum    = cfg_data[GAIN_W-1:0];
                CFG_GAIN_DIFF:   cfg_next.gain_diff   = cfg_data[GAIN_W-1:0];
                CFG_DUTY_SCALE:  cfg_next.duty_scale  = cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{target_temp: TARGET_RST, gain_prop: GAIN_PROP_RST,
                         gain_sum: GAIN_SUM_RST, gain_diff: GAIN_DIFF_RST,
                         duty_scale: DUTY_SCALE_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tpd_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    tpd_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .ctrl            (ctrl),
        .s_measured_temp (s_measured_temp),
        .status          (status),
        .m_pwm_duty      (m_pwm_duty),
        .m_drive_level   (m_drive_level),
        .m_ceiling_zero  (m_ceiling_zero)
    );

endmodule
